/* rtl/core/status_led_color_animator_top_defines.svh */
// assertion macros used by the checker file
`ifndef STATUS_LED_COLOR_ANIMATOR_TOP_DEFINES_SVH
`define STATUS_LED_COLOR_ANIMATOR_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define SLCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define SLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/slca_pkg.sv */
package slca_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CFG_PUBLIC_SCHEME    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CHIP_VARIANT_ALT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS       = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_NORMAL     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_SMART      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_CUSTOM     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_COLOR_OFF        = 3'd6;

  // configuration reset values
  localparam logic [31:0] RST_BRIGHTNESS   = 32'd1009319935;
  localparam logic [23:0] RST_COLOR_NORMAL = 24'h00ff00;
  localparam logic [23:0] RST_COLOR_SMART  = 24'hff0000;
  localparam logic [23:0] RST_COLOR_CUSTOM = 24'hffffff;
  localparam logic [23:0] RST_COLOR_OFF    = 24'h000000;

  // charger states
  localparam logic [3:0] EVSE_A          = 4'd0;
  localparam logic [3:0] EVSE_B          = 4'd1;
  localparam logic [3:0] EVSE_C          = 4'd2;
  localparam logic [3:0] EVSE_B1         = 4'd9;
  localparam logic [3:0] EVSE_MODEM_REQ  = 4'd11;
  localparam logic [3:0] EVSE_MODEM_WAIT = 4'd12;
  localparam logic [3:0] EVSE_DENIED     = 4'd14;

  // error flag bit positions
  localparam int unsigned EF_BIT_CT       = 1;
  localparam int unsigned EF_BIT_TEMP     = 2;
  localparam int unsigned EF_BIT_EV       = 3;
  localparam int unsigned EF_BIT_RCM_TRIP = 4;
  localparam int unsigned EF_BIT_RCM_TEST = 5;

  // flash flag bit positions
  localparam int unsigned FL_BIT_CARD     = 0;
  localparam int unsigned FL_BIT_AUTH     = 1;
  localparam int unsigned FL_BIT_REJECTED = 2;
  localparam int unsigned FL_BIT_TIMEOUT  = 3;

  // point status codes
  localparam logic [1:0] PS_OTHER    = 2'd0;
  localparam logic [1:0] PS_RESERVED = 2'd1;

  // fixed public scheme colors, red in the low byte
  localparam logic [23:0] COLOR_PUB_CARD   = 24'h808080;
  localparam logic [23:0] COLOR_PUB_GREEN  = 24'h00ff00;
  localparam logic [23:0] COLOR_PUB_RED    = 24'h0000ff;
  localparam logic [23:0] COLOR_PUB_ORANGE = 24'h0080ff;
  localparam logic [23:0] COLOR_BLACK      = 24'h000000;

  // animation constants
  localparam logic [7:0] PHASE_STEP_ERROR = 8'd20;
  localparam logic [7:0] PHASE_STEP_SLOW  = 8'd2;
  localparam logic [7:0] PHASE_MID        = 8'h80;
  localparam logic [7:0] ERROR_ON_THRESH  = 8'd128;
  localparam logic [7:0] WAIT_ON_THRESH   = 8'd230;

  // what the back end does with the animation state
  typedef enum logic [2:0] {
    KIND_HOLD,
    KIND_ERROR,
    KIND_WAIT,
    KIND_LEVEL,
    KIND_BREATHE
  } kind_e;

  // how the brightness turns into a color
  typedef enum logic [2:0] {
    OUT_SCALE,
    OUT_CONST,
    OUT_AMBER,
    OUT_RED,
    OUT_GREEN,
    OUT_BLUE
  } out_mode_e;

  // classified request passed from front to back
  typedef struct packed {
    kind_e       kind;
    out_mode_e   mode;
    logic        set_phase;
    logic [7:0]  level;
    logic [23:0] color;
  } cmd_t;

endpackage

/* rtl/core/slca_in_if.sv */
interface slca_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] evse_state;
  logic [7:0] err_bits;
  logic       rcm_test_active;
  logic       acc_off;
  logic       custom_pressed;
  logic       charge_delayed;
  logic       smart_mode;
  logic [3:0] flash_flags;
  logic [1:0] point_status;

  modport source (
    output valid, evse_state, err_bits, rcm_test_active, acc_off,
           custom_pressed, charge_delayed, smart_mode, flash_flags, point_status,
    input  ready
  );

  modport sink (
    input  valid, evse_state, err_bits, rcm_test_active, acc_off,
           custom_pressed, charge_delayed, smart_mode, flash_flags, point_status,
    output ready
  );
endinterface

/* rtl/core/slca_out_if.sv */
interface slca_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );

  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface

/* rtl/core/slca_front.sv */
module slca_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [slca_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [slca_pkg::CfgDataW-1:0]  cfg_data_i,
  slca_in_if.sink                        in_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output slca_pkg::cmd_t                 cmd_o
);

  logic        public_q;
  logic        alt_q;
  logic [31:0] levels_q;
  logic [23:0] col_normal_q;
  logic [23:0] col_smart_q;
  logic [23:0] col_custom_q;
  logic [23:0] col_off_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      public_q     <= 1'b0;
      alt_q        <= 1'b0;
      levels_q     <= slca_pkg::RST_BRIGHTNESS;
      col_normal_q <= slca_pkg::RST_COLOR_NORMAL;
      col_smart_q  <= slca_pkg::RST_COLOR_SMART;
      col_custom_q <= slca_pkg::RST_COLOR_CUSTOM;
      col_off_q    <= slca_pkg::RST_COLOR_OFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        slca_pkg::CFG_PUBLIC_SCHEME:    public_q     <= cfg_data_i[0];
        slca_pkg::CFG_CHIP_VARIANT_ALT: alt_q        <= cfg_data_i[0];
        slca_pkg::CFG_BRIGHTNESS:       levels_q     <= cfg_data_i[31:0];
        slca_pkg::CFG_COLOR_NORMAL:     col_normal_q <= cfg_data_i[23:0];
        slca_pkg::CFG_COLOR_SMART:      col_smart_q  <= cfg_data_i[23:0];
        slca_pkg::CFG_COLOR_CUSTOM:     col_custom_q <= cfg_data_i[23:0];
        slca_pkg::CFG_COLOR_OFF:        col_off_q    <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // status decode
  logic [7:0]  ef;
  logic        st_a;
  logic        st_c;
  logic        st_b_like;
  logic        hw_err;
  logic        rcm_mismatch;
  logic        error_now;
  logic        wait_pending;
  logic [23:0] mode_color;

  assign ef        = in_i.err_bits;
  assign st_a      = (in_i.evse_state == slca_pkg::EVSE_A);
  assign st_c      = (in_i.evse_state == slca_pkg::EVSE_C);
  assign st_b_like = (in_i.evse_state == slca_pkg::EVSE_B)
                  || (in_i.evse_state == slca_pkg::EVSE_B1)
                  || (in_i.evse_state == slca_pkg::EVSE_MODEM_REQ)
                  || (in_i.evse_state == slca_pkg::EVSE_MODEM_WAIT);

  assign hw_err = ef[slca_pkg::EF_BIT_CT] | ef[slca_pkg::EF_BIT_TEMP]
                | ef[slca_pkg::EF_BIT_EV];
  assign rcm_mismatch = (ef[slca_pkg::EF_BIT_RCM_TRIP] ^ ef[slca_pkg::EF_BIT_RCM_TEST])
                      & ~in_i.rcm_test_active;
  assign error_now = alt_q ? (hw_err | rcm_mismatch)
                           : (hw_err | ef[slca_pkg::EF_BIT_RCM_TRIP]);
  assign wait_pending = (|ef) | in_i.charge_delayed;

  assign mode_color = in_i.custom_pressed ? col_custom_q :
                      (in_i.smart_mode ? col_smart_q : col_normal_q);

  // classify the request by priority
  always_comb begin
    cmd_o.kind      = slca_pkg::KIND_HOLD;
    cmd_o.mode      = slca_pkg::OUT_CONST;
    cmd_o.set_phase = 1'b0;
    cmd_o.level     = 8'd0;
    cmd_o.color     = slca_pkg::COLOR_BLACK;
    if (public_q) begin
      if (in_i.flash_flags[slca_pkg::FL_BIT_CARD]) begin
        cmd_o.color = slca_pkg::COLOR_PUB_CARD;
      end else if (in_i.flash_flags[slca_pkg::FL_BIT_AUTH]) begin
        cmd_o.color = slca_pkg::COLOR_PUB_GREEN;
      end else if (in_i.flash_flags[slca_pkg::FL_BIT_REJECTED]
                || in_i.flash_flags[slca_pkg::FL_BIT_TIMEOUT]) begin
        cmd_o.color = slca_pkg::COLOR_PUB_RED;
      end else if (in_i.point_status == slca_pkg::PS_RESERVED) begin
        cmd_o.color = slca_pkg::COLOR_PUB_ORANGE;
      end else if (in_i.point_status != slca_pkg::PS_OTHER) begin
        // unavailable or faulted
        cmd_o.color = slca_pkg::COLOR_PUB_RED;
      end else if (wait_pending) begin
        cmd_o.kind  = slca_pkg::KIND_WAIT;
        cmd_o.mode  = slca_pkg::OUT_AMBER;
        cmd_o.level = levels_q[15:8];
      end else if (st_a) begin
        cmd_o.kind  = slca_pkg::KIND_LEVEL;
        cmd_o.mode  = slca_pkg::OUT_GREEN;
        cmd_o.level = levels_q[23:16];
      end else if (st_b_like) begin
        cmd_o.kind      = slca_pkg::KIND_LEVEL;
        cmd_o.mode      = slca_pkg::OUT_BLUE;
        cmd_o.level     = levels_q[31:24];
        cmd_o.set_phase = 1'b1;
      end else if (st_c) begin
        cmd_o.kind = slca_pkg::KIND_BREATHE;
        cmd_o.mode = slca_pkg::OUT_BLUE;
      end
    end else begin
      if (error_now) begin
        cmd_o.kind  = slca_pkg::KIND_ERROR;
        cmd_o.mode  = slca_pkg::OUT_RED;
        cmd_o.level = levels_q[7:0];
      end else if (in_i.acc_off && in_i.custom_pressed) begin
        cmd_o.color = col_custom_q;
      end else if (in_i.acc_off || (in_i.evse_state == slca_pkg::EVSE_DENIED)) begin
        cmd_o.color = col_off_q;
      end else begin
        cmd_o.mode  = slca_pkg::OUT_SCALE;
        cmd_o.color = mode_color;
        if (wait_pending) begin
          cmd_o.kind  = slca_pkg::KIND_WAIT;
          cmd_o.level = levels_q[15:8];
        end else if (st_a) begin
          cmd_o.kind  = slca_pkg::KIND_LEVEL;
          cmd_o.level = levels_q[23:16];
        end else if (st_b_like) begin
          cmd_o.kind      = slca_pkg::KIND_LEVEL;
          cmd_o.level     = levels_q[31:24];
          cmd_o.set_phase = 1'b1;
        end else if (st_c) begin
          cmd_o.kind = slca_pkg::KIND_BREATHE;
        end
      end
    end
  end

  // handshake passes straight to the queue
  assign cmd_valid_o = in_i.valid;
  assign in_i.ready  = cmd_ready_i;

endmodule

/* rtl/core/slca_cmd_fifo.sv */
module slca_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  slca_pkg::cmd_t push_data_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output slca_pkg::cmd_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  slca_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  logic            pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/slca_back.sv */
module slca_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  slca_pkg::cmd_t cmd_i,
  slca_out_if.source     out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEVEL,
    ST_CHAN
  } state_e;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  // triangle wave followed by the quadratic ease
  function automatic logic [7:0] breathe_level(input logic [7:0] p);
    logic [7:0]  t;
    logic [7:0]  m;
    logic [7:0]  r;
    logic [16:0] prod;
    t    = p[7] ? ~p : p;
    t    = {t[6:0], 1'b0};
    m    = t[7] ? ~t : t;
    prod = {9'd0, m} * {8'd0, ({1'b0, m} + 9'd1)};
    r    = {prod[14:8], 1'b0};
    if (t[7]) begin
      r = ~r;
    end
    return r;
  endfunction

  state_e         state_q, state_d;
  slca_pkg::cmd_t cmd_q, cmd_d;
  logic [7:0]     phase_q, phase_d;
  logic [7:0]     lb_q, lb_d;
  logic [1:0]     chan_q, chan_d;
  logic [23:0]    rgb_q, rgb_d;
  logic           out_valid_q, out_valid_d;
  logic [23:0]    out_rgb_q, out_rgb_d;

  // shared channel multiplier, product / 255 by reciprocal trick
  logic [7:0]  col_byte;
  logic [15:0] prod;
  logic [16:0] div_sum;
  logic [7:0]  scaled;
  logic [7:0]  chan_val;

  assign col_byte = cmd_q.color[7:0];
  assign prod     = {8'd0, lb_q} * {8'd0, col_byte};
  assign div_sum  = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
  assign scaled   = div_sum[15:8];

  // value of the current channel
  always_comb begin
    case (cmd_q.mode)
      slca_pkg::OUT_SCALE: chan_val = scaled;
      slca_pkg::OUT_CONST: chan_val = col_byte;
      slca_pkg::OUT_AMBER: begin
        if (chan_q == CHAN_RED) begin
          chan_val = lb_q;
        end else if (chan_q == CHAN_GREEN) begin
          chan_val = {1'b0, lb_q[7:1]};
        end else begin
          chan_val = 8'd0;
        end
      end
      slca_pkg::OUT_RED:   chan_val = (chan_q == CHAN_RED) ? lb_q : 8'd0;
      slca_pkg::OUT_GREEN: chan_val = (chan_q == CHAN_GREEN) ? lb_q : 8'd0;
      slca_pkg::OUT_BLUE:  chan_val = (chan_q == CHAN_BLUE) ? lb_q : 8'd0;
      default:             chan_val = 8'd0;
    endcase
  end

  // sequencer: take request, step animation, run three channels
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    phase_d     = phase_q;
    lb_d        = lb_q;
    chan_d      = chan_q;
    rgb_d       = rgb_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_rgb_d   = out_rgb_q;
    cmd_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = ST_LEVEL;
          case (cmd_i.kind)
            slca_pkg::KIND_ERROR:   phase_d = phase_q + slca_pkg::PHASE_STEP_ERROR;
            slca_pkg::KIND_WAIT,
            slca_pkg::KIND_BREATHE: phase_d = phase_q + slca_pkg::PHASE_STEP_SLOW;
            slca_pkg::KIND_LEVEL: begin
              if (cmd_i.set_phase) begin
                phase_d = slca_pkg::PHASE_MID;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LEVEL: begin
        case (cmd_q.kind)
          slca_pkg::KIND_ERROR:
            lb_d = (phase_q > slca_pkg::ERROR_ON_THRESH) ? cmd_q.level : 8'd0;
          slca_pkg::KIND_WAIT:
            lb_d = (phase_q > slca_pkg::WAIT_ON_THRESH) ? cmd_q.level : 8'd0;
          slca_pkg::KIND_LEVEL:   lb_d = cmd_q.level;
          slca_pkg::KIND_BREATHE: lb_d = breathe_level(phase_q);
          default: ;
        endcase
        chan_d  = CHAN_RED;
        state_d = ST_CHAN;
      end
      ST_CHAN: begin
        if (chan_q == CHAN_BLUE) begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_d = 1'b1;
            out_rgb_d   = {chan_val, rgb_q[23:8]};
            state_d     = ST_IDLE;
          end
        end else begin
          rgb_d       = {chan_val, rgb_q[23:8]};
          cmd_d.color = {8'd0, cmd_q.color[23:8]};
          chan_d      = chan_q + 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      phase_q     <= 8'd0;
      lb_q        <= 8'd0;
      chan_q      <= CHAN_RED;
      rgb_q       <= '0;
      out_valid_q <= 1'b0;
      out_rgb_q   <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      phase_q     <= phase_d;
      lb_q        <= lb_d;
      chan_q      <= chan_d;
      rgb_q       <= rgb_d;
      out_valid_q <= out_valid_d;
      out_rgb_q   <= out_rgb_d;
    end
  end

  // output register
  assign out_o.valid = out_valid_q;
  assign out_o.red   = out_rgb_q[7:0];
  assign out_o.green = out_rgb_q[15:8];
  assign out_o.blue  = out_rgb_q[23:16];

endmodule

/* rtl/core/status_led_color_animator_top.sv */
// Status LED color animator: every accepted request is one animation tick with a charger
// status snapshot and yields exactly one RGB triple, in order. The front end decodes the
// status against the configuration registers into a short command that waits in a small
// queue (QueueDepth entries); the back end owns the phase counter and last brightness and
// turns each command into a color. In the back end a tick takes the command, makes the
// brightness step (which holds the breathing ease multiplier) and then runs a channel step
// for red, green and blue in turn, which share one multiplier; a result that is not
// taken holds the back end in its last channel step. The output is registered, so the
// queue keeps accepting ticks while a result waits. Configuration registers are written
// through cfg_we_i / cfg_idx_i / cfg_data_i and must only change while no tick is in flight.
module status_led_color_animator_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [slca_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [slca_pkg::CfgDataW-1:0] cfg_data_i,
  slca_in_if.sink                       in_i,
  slca_out_if.source                    out_o
);

  logic           fe_valid;
  logic           fe_ready;
  slca_pkg::cmd_t fe_cmd;
  logic           be_valid;
  logic           be_ready;
  slca_pkg::cmd_t be_cmd;

  // decode and configuration
  slca_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  // command queue
  slca_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_data_o   (be_cmd)
  );

  // animation and color
  slca_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .out_o       (out_o)
  );

endmodule

/* rtl/core/slca_checker.sv */
`include "status_led_color_animator_top_defines.svh"

module slca_checker #(
  parameter int unsigned MaxPending = 4
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] red_i,
  input logic [7:0] green_i,
  input logic [7:0] blue_i
);

  localparam int unsigned PendW = $clog2(MaxPending + 1);

  logic             in_acc;
  logic             out_acc;
  logic [PendW-1:0] pending_q;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // ticks taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  // a stalled result stays offered
  `SLCA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // a stalled result keeps its color
  `SLCA_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
                    $stable(red_i) && $stable(green_i) && $stable(blue_i), "result changed")

  // no result without a tick behind it
  `SLCA_ASSERT_NOW(a_no_spurious, out_valid_i, pending_q != '0, "result without tick")

  // queue, back end and output register all full means no more ticks
  `SLCA_ASSERT_NOW(a_bounded, pending_q == PendW'(MaxPending), !in_ready_i,
                   "ready with all stages full")

endmodule

bind status_led_color_animator_top slca_checker #(
  .MaxPending (QueueDepth + 2)
) u_slca_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_i       (out_o.red),
  .green_i     (out_o.green),
  .blue_i      (out_o.blue)
);
